// File: src/ihcc_pkg.sv
`timescale 1ns / 1ps
package ihcc_pkg;

  localparam int DATA_W      = 8;
  localparam int STATUS_W    = 4;
  localparam int ACTION_W    = 2;
  localparam int ADDR_W      = 32;
  localparam int HDR_BYTES_W = 6;
  localparam int PKT_LEN_W   = 16;
  localparam int COUNT_W     = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0]   COUNT_MAX      = '1;
  localparam logic [COUNT_W-1:0]   MIN_HDR_LEN    = 17'd20;
  localparam logic [3:0]           IPV4_VER       = 4'd4;
  localparam logic [ADDR_W-1:0]    BROADCAST_ADDR = '1;
  localparam logic [PKT_LEN_W-1:0] SUM_GOOD       = '1;

  // byte offsets inside the header
  localparam logic [COUNT_W-1:0] OFS_VER_IHL  = 17'd0;
  localparam logic [COUNT_W-1:0] OFS_TLEN_HI  = 17'd2;
  localparam logic [COUNT_W-1:0] OFS_TLEN_LO  = 17'd3;
  localparam logic [COUNT_W-1:0] OFS_TTL      = 17'd8;
  localparam logic [COUNT_W-1:0] OFS_PROTO    = 17'd9;
  localparam logic [COUNT_W-1:0] OFS_SRC_LO   = 17'd12;
  localparam logic [COUNT_W-1:0] OFS_SRC_HI   = 17'd15;
  localparam logic [COUNT_W-1:0] OFS_DST_LO   = 17'd16;
  localparam logic [COUNT_W-1:0] OFS_DST_HI   = 17'd19;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOCAL_ADDRESS     = 1'd0,
    REG_MAX_PACKET_LENGTH = 1'd1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 4'd0,
    ST_TOO_SMALL = 4'd1,
    ST_TOO_BIG   = 4'd2,
    ST_VERSION   = 4'd3,
    ST_IHL       = 4'd4,
    ST_CHECKSUM  = 4'd5,
    ST_PROTOCOL  = 4'd6,
    ST_TOT_LEN   = 4'd7,
    ST_TTL       = 4'd8
  } status_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DROP        = 2'd0,
    ACT_DELIVER     = 2'd1,
    ACT_ICMP_PROTO  = 2'd2,
    ACT_ICMP_TTL    = 2'd3
  } action_t;

endpackage

// File: src/ihcc_in_if.sv
`timescale 1ns / 1ps
interface ihcc_in_if
  import ihcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/ihcc_out_if.sv
`timescale 1ns / 1ps
interface ihcc_out_if
  import ihcc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [ACTION_W-1:0]    action;
  logic [ADDR_W-1:0]      reply_address;
  logic [HDR_BYTES_W-1:0] header_bytes;

  modport source (output valid, output status, output action, output reply_address,
                  output header_bytes, input ready);
  modport sink   (input valid, input status, input action, input reply_address,
                  input header_bytes, output ready);
endinterface

// File: src/ihcc_cfg_if.sv
`timescale 1ns / 1ps
interface ihcc_cfg_if
  import ihcc_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/ipv4_header_check_classify_core.sv
`timescale 1ns / 1ps
// IPv4 header check and classify. Packet bytes enter on in_ch one per transfer, header
// first, with last_byte set on the final byte; one verdict per packet leaves on out_ch
// (status, action, source address as reply_address, and IHL times four). The block
// takes one byte every cycle unless stalled: a byte sits in the input register, its
// header capture and checksum add are done there, and on the last byte the verdict
// is written to the result register, from which it is presented on out_ch. The input
// side stalls only when a last byte is waiting and the result register still holds an
// untaken result. cfg_ch is always ready; index 0 writes local_address, index 1 writes
// max_packet_length. Writes are to be made only while no packet is in flight; the
// user must keep to this, as the block itself does not enforce it.
module ipv4_header_check_classify_core
  import ihcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ihcc_in_if.sink           in_ch,
  ihcc_out_if.source        out_ch,
  ihcc_cfg_if.sink          cfg_ch
);

  // configuration
  logic [ADDR_W-1:0]    local_addr_r;
  logic [PKT_LEN_W-1:0] max_len_r;

  // input register
  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_last_r;

  // per-packet state
  logic [COUNT_W-1:0]   count_r,  count_nxt;
  logic [PKT_LEN_W-1:0] sum_r,    sum_nxt;
  logic [7:0]           hold_r,   hold_nxt;
  logic [7:0]           vi_r,     vi_nxt;
  logic [PKT_LEN_W-1:0] tlen_r,   tlen_nxt;
  logic [7:0]           ttl_r,    ttl_nxt;
  logic [7:0]           proto_r,  proto_nxt;
  logic [ADDR_W-1:0]    src_r,    src_nxt;
  logic [ADDR_W-1:0]    dst_r,    dst_nxt;

  // result register
  logic                   out_valid_r;
  status_t                status_r, status_nxt;
  action_t                action_r, action_nxt;
  logic [ADDR_W-1:0]      reply_r;
  logic [HDR_BYTES_W-1:0] hbytes_r, hl;

  logic                   out_free, s1_go, pkt_end, in_xfer;
  logic [PKT_LEN_W:0]     sum_wide;
  logic                   proto_ok, dst_match;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign pkt_end  = s1_go && s1_last_r;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      max_len_r    <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LOCAL_ADDRESS:     local_addr_r <= cfg_ch.data;
        REG_MAX_PACKET_LENGTH: max_len_r    <= cfg_ch.data[PKT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // header capture, checksum and verdict for the byte in the input register
  always_comb begin
    vi_nxt    = vi_r;
    tlen_nxt  = tlen_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    hold_nxt  = hold_r;
    sum_nxt   = sum_r;

    if (count_r == OFS_VER_IHL) vi_nxt = s1_data_r;
    if (count_r == OFS_TLEN_HI) tlen_nxt = {s1_data_r, tlen_r[7:0]};
    if (count_r == OFS_TLEN_LO) tlen_nxt = {tlen_r[15:8], s1_data_r};
    if (count_r == OFS_TTL)     ttl_nxt = s1_data_r;
    if (count_r == OFS_PROTO)   proto_nxt = s1_data_r;
    if (count_r >= OFS_SRC_LO && count_r <= OFS_SRC_HI) src_nxt = {src_r[23:0], s1_data_r};
    if (count_r >= OFS_DST_LO && count_r <= OFS_DST_HI) dst_nxt = {dst_r[23:0], s1_data_r};

    hl = {vi_nxt[3:0], 2'b00};

    // end-around carry add over header words
    sum_wide = {1'b0, sum_r} + {1'b0, hold_r, s1_data_r};
    if (count_r < COUNT_W'(hl)) begin
      if (!count_r[0]) hold_nxt = s1_data_r;
      else             sum_nxt  = sum_wide[PKT_LEN_W-1:0] + PKT_LEN_W'(sum_wide[PKT_LEN_W]);
    end

    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

    proto_ok  = (proto_nxt == PROTO_ICMP) || (proto_nxt == PROTO_TCP) ||
                (proto_nxt == PROTO_UDP);
    dst_match = (dst_nxt == local_addr_r) || (dst_nxt == BROADCAST_ADDR);

    if (count_nxt < MIN_HDR_LEN)                                  status_nxt = ST_TOO_SMALL;
    else if (count_nxt > {1'b0, max_len_r})                       status_nxt = ST_TOO_BIG;
    else if (vi_nxt[7:4] != IPV4_VER)                             status_nxt = ST_VERSION;
    else if (COUNT_W'(hl) < MIN_HDR_LEN || count_nxt < COUNT_W'(hl))
                                                                  status_nxt = ST_IHL;
    else if (sum_nxt != SUM_GOOD)                                 status_nxt = ST_CHECKSUM;
    else if (!proto_ok)                                           status_nxt = ST_PROTOCOL;
    else if (tlen_nxt < PKT_LEN_W'(hl) || count_nxt < {1'b0, tlen_nxt})
                                                                  status_nxt = ST_TOT_LEN;
    else if (ttl_nxt <= 8'd1)                                     status_nxt = ST_TTL;
    else                                                          status_nxt = ST_OK;

    if (status_nxt == ST_OK)                             action_nxt = ACT_DELIVER;
    else if (dst_match && status_nxt == ST_PROTOCOL)     action_nxt = ACT_ICMP_PROTO;
    else if (dst_match && status_nxt == ST_TTL)          action_nxt = ACT_ICMP_TTL;
    else                                                 action_nxt = ACT_DROP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || pkt_end) begin
      count_r <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      vi_r    <= '0;
      tlen_r  <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (s1_go) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      vi_r    <= vi_nxt;
      tlen_r  <= tlen_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pkt_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_end) begin
      status_r <= status_nxt;
      action_r <= action_nxt;
      reply_r  <= src_nxt;
      hbytes_r <= hl;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.action        = action_r;
  assign out_ch.reply_address = reply_r;
  assign out_ch.header_bytes  = hbytes_r;

endmodule

// File: src/ihcc_checker.sv
`timescale 1ns / 1ps
module ihcc_checker
  import ihcc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    out_status,
  input logic [ACTION_W-1:0]    out_action,
  input logic [ADDR_W-1:0]      out_reply_address,
  input logic [HDR_BYTES_W-1:0] out_header_bytes
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_action)
      && $stable(out_reply_address) && $stable(out_header_bytes))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_action == ACT_DELIVER)
    else $error("passing packet not delivered");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ICMP_PROTO |-> out_status == ST_PROTOCOL)
    else $error("protocol unreachable without protocol failure");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ICMP_TTL |-> out_status == ST_TTL)
    else $error("ttl exceeded without ttl failure");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_header_bytes[1:0] == 2'b00)
    else $error("header length not a multiple of four");

endmodule

bind ipv4_header_check_classify_core ihcc_checker u_ihcc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_action        (out_ch.action),
  .out_reply_address (out_ch.reply_address),
  .out_header_bytes  (out_ch.header_bytes)
);

// File: tb/tb_ipv4_header_check_classify_core.sv
`timescale 1ns / 1ps
module tb_ipv4_header_check_classify_core;
  import ihcc_pkg::*;

  localparam int unsigned HOLD_LEN = 300;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  typedef struct packed {
    status_t                status;
    action_t                action;
    logic [ADDR_W-1:0]      reply_address;
    logic [HDR_BYTES_W-1:0] header_bytes;
  } verdict_t;

  logic clk;
  logic rst_n;

  ihcc_in_if  in_ch();
  ihcc_out_if out_ch();
  ihcc_cfg_if cfg_ch();

  ipv4_header_check_classify_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pkt_byte_t   tx_bytes[$];
  verdict_t    verdicts_due[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles = 0;
  int unsigned hold_req;
  int unsigned hold_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned phase_bytes;

  // register copies
  logic [ADDR_W-1:0]    local_addr;
  logic [PKT_LEN_W-1:0] max_len;

  // header fields tracked for the packet in progress
  logic [COUNT_W-1:0] cnt;
  logic [15:0]        hdr_sum;
  logic [7:0]         hi_byte;
  logic [7:0]         ver_ihl;
  logic [15:0]        tot_len;
  logic [7:0]         ttl;
  logic [7:0]         proto;
  logic [ADDR_W-1:0]  src_addr;
  logic [ADDR_W-1:0]  dst_addr;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_packet_state();
    cnt      = '0;
    hdr_sum  = '0;
    hi_byte  = '0;
    ver_ihl  = '0;
    tot_len  = '0;
    ttl      = '0;
    proto    = '0;
    src_addr = '0;
    dst_addr = '0;
  endtask

  // follow one transferred byte, queue a verdict on the last one
  task automatic track_byte(input logic [7:0] b, input logic last);
    logic [COUNT_W-1:0] idx;
    logic [6:0]         hl;
    logic [16:0]        s;
    verdict_t           v;
    idx = cnt;
    case (idx)
      OFS_VER_IHL: ver_ihl = b;
      OFS_TLEN_HI: tot_len[15:8] = b;
      OFS_TLEN_LO: tot_len[7:0] = b;
      OFS_TTL:     ttl = b;
      OFS_PROTO:   proto = b;
      default: ;
    endcase
    if (idx >= OFS_SRC_LO && idx <= OFS_SRC_HI) src_addr = {src_addr[23:0], b};
    if (idx >= OFS_DST_LO && idx <= OFS_DST_HI) dst_addr = {dst_addr[23:0], b};
    hl = {1'b0, ver_ihl[3:0], 2'b00};
    if (idx < hl) begin
      if (!idx[0]) begin
        hi_byte = b;
      end else begin
        s = {1'b0, hdr_sum} + {1'b0, hi_byte, b};
        hdr_sum = s[15:0] + s[16];
      end
    end
    if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
    if (last) begin
      if (cnt < MIN_HDR_LEN) v.status = ST_TOO_SMALL;
      else if (cnt > max_len) v.status = ST_TOO_BIG;
      else if (ver_ihl[7:4] != IPV4_VER) v.status = ST_VERSION;
      else if (hl < MIN_HDR_LEN || cnt < hl) v.status = ST_IHL;
      else if (hdr_sum != SUM_GOOD) v.status = ST_CHECKSUM;
      else if (proto != PROTO_ICMP && proto != PROTO_TCP && proto != PROTO_UDP)
        v.status = ST_PROTOCOL;
      else if (tot_len < hl || cnt < tot_len) v.status = ST_TOT_LEN;
      else if (ttl <= 8'd1) v.status = ST_TTL;
      else v.status = ST_OK;
      v.action = ACT_DROP;
      if (v.status == ST_OK) begin
        v.action = ACT_DELIVER;
      end else if (dst_addr == local_addr || dst_addr == BROADCAST_ADDR) begin
        if (v.status == ST_PROTOCOL) v.action = ACT_ICMP_PROTO;
        else if (v.status == ST_TTL) v.action = ACT_ICMP_TTL;
      end
      v.reply_address = src_addr;
      v.header_bytes  = hl[5:0];
      verdicts_due.push_back(v);
      clear_packet_state();
    end
  endtask

  // byte driver
  always @(posedge clk) begin : drive_bytes
    pkt_byte_t nb;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= '0;
      in_ch.last_byte <= 1'b0;
      clear_packet_state();
    end else begin
      if (in_ch.valid && in_ch.ready) track_byte(in_ch.data_byte, in_ch.last_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = tx_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= nb.data;
          in_ch.last_byte <= nb.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status        = status_t'(out_ch.status);
        got.action        = action_t'(out_ch.action);
        got.reply_address = out_ch.reply_address;
        got.header_bytes  = out_ch.header_bytes;
        if (verdicts_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected verdict: status %0d action %0d reply %h hdr %0d",
                     got.status, got.action, got.reply_address, got.header_bytes);
        end else begin
          want = verdicts_due.pop_front();
          if (got.status !== want.status || got.action !== want.action ||
              got.reply_address !== want.reply_address ||
              got.header_bytes !== want.header_bytes) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("verdict mismatch: expected status %0d action %0d reply %h hdr %0d",
                       want.status, want.action, want.reply_address, want.header_bytes,
                       ", got status %0d action %0d reply %h hdr %0d",
                       got.status, got.action, got.reply_address, got.header_bytes);
          end
        end
      end
      out_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cycles <= HOLD_LEN;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  task automatic cfg_write(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (which)
      REG_LOCAL_ADDRESS:     local_addr = val;
      REG_MAX_PACKET_LENGTH: max_len = val[PKT_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_ch.valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    pkt_byte_t nb;
    nb.data = b;
    nb.last = last;
    tx_bytes.push_back(nb);
    phase_bytes++;
  endtask

  task automatic noise_packet(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_byte(8'($urandom_range(255)), i == n - 1);
  endtask

  // header with random filler, checksum fixed up unless sum_ok is clear;
  // pkt_len may cut the header short or add payload
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [15:0] tlen, input logic [7:0] ttl_v,
                              input logic [7:0] proto_v, input logic [31:0] dst,
                              input bit sum_ok, input int unsigned pkt_len);
    logic [7:0]  hdr [0:59];
    int unsigned hlen;
    int unsigned i;
    logic [16:0] acc;
    logic [15:0] csum;
    hlen = (ihl < 5) ? 20 : ihl * 4;
    for (i = 0; i < 60; i++) hdr[i] = 8'($urandom_range(255));
    hdr[0]  = {ver, ihl};
    hdr[2]  = tlen[15:8];
    hdr[3]  = tlen[7:0];
    hdr[8]  = ttl_v;
    hdr[9]  = proto_v;
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    {hdr[12], hdr[13], hdr[14], hdr[15]} = $urandom;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    acc = '0;
    for (i = 0; i < ihl * 4; i += 2) begin
      acc = {1'b0, acc[15:0]} + {1'b0, hdr[i], hdr[i+1]};
      acc = acc[15:0] + acc[16];
    end
    csum = ~acc[15:0];
    if (!sum_ok) csum = csum ^ 16'($urandom_range(1, 65535));
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    for (i = 0; i < pkt_len; i++)
      push_byte((i < hlen) ? hdr[i] : 8'($urandom_range(255)), i == pkt_len - 1);
  endtask

  task automatic rand_packet();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tlen;
    logic [7:0]  ttl_v;
    logic [7:0]  proto_v;
    logic [31:0] dst;
    int unsigned hlen;
    int unsigned pay;
    int unsigned plen;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      noise_packet($urandom_range(1, 40));
    end else begin
      ver = ($urandom_range(99) < 92) ? IPV4_VER : 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 60) ihl = 4'd5;
      else if (pick < 92) ihl = 4'($urandom_range(6, 15));
      else ihl = 4'($urandom_range(0, 4));
      hlen = (ihl < 5) ? 20 : ihl * 4;
      pay = ($urandom_range(99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 200);
      plen = hlen + pay;
      pick = $urandom_range(99);
      if (pick < 80) tlen = 16'(plen);
      else if (pick < 90) tlen = 16'(hlen + $urandom_range(0, pay));
      else tlen = 16'($urandom);
      // truncated header
      if ($urandom_range(99) < 8) plen = $urandom_range(1, hlen);
      ttl_v = ($urandom_range(99) < 85) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1));
      pick = $urandom_range(99);
      if (pick < 30) proto_v = PROTO_ICMP;
      else if (pick < 58) proto_v = PROTO_TCP;
      else if (pick < 86) proto_v = PROTO_UDP;
      else proto_v = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) dst = local_addr;
      else if (pick < 50) dst = BROADCAST_ADDR;
      else dst = $urandom;
      build_packet(ver, ihl, tlen, ttl_v, proto_v, dst, $urandom_range(99) < 90, plen);
    end
  endtask

  task automatic rand_phase(input int unsigned n);
    phase_bytes = 0;
    while (phase_bytes < n) rand_packet();
  endtask

  initial begin
    int unsigned i;
    rst_n            = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_LOCAL_ADDRESS;
    cfg_ch.data      = '0;
    hold_req         = 0;
    phase_bytes      = 0;
    send_idle_pct    = 36;
    recv_idle_pct    = 46;
    local_addr       = '0;
    max_len          = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_LOCAL_ADDRESS, $urandom);
    cfg_write(REG_MAX_PACKET_LENGTH, 32'h0000_FFFF);
    @(negedge clk);
    // directed packets
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 20);
    build_packet(IPV4_VER, 4'd15, 16'd68, 8'd255, PROTO_UDP, BROADCAST_ADDR, 1, 68);
    build_packet(IPV4_VER, 4'd5, 16'd24, 8'd2, PROTO_ICMP, local_addr, 1, 30);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, 8'hFF, local_addr, 1, 20);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, 8'h00, local_addr ^ 32'h1, 1, 20);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd1, PROTO_TCP, BROADCAST_ADDR, 1, 20);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd0, PROTO_UDP, local_addr, 1, 20);
    build_packet(4'd6, 4'd5, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 20);
    build_packet(4'hF, 4'd5, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 20);
    build_packet(IPV4_VER, 4'd4, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 20);
    build_packet(IPV4_VER, 4'd0, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 20);
    // header longer than the packet
    build_packet(IPV4_VER, 4'd15, 16'd60, 8'd64, PROTO_TCP, local_addr, 1, 40);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, PROTO_TCP, local_addr, 0, 20);
    build_packet(IPV4_VER, 4'd5, 16'd21, 8'd64, PROTO_TCP, local_addr, 1, 20);
    build_packet(IPV4_VER, 4'd6, 16'd0, 8'd64, PROTO_UDP, local_addr, 1, 24);
    // short packets, then an all-zero 20-byte packet
    push_byte(8'hFF, 1'b1);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, PROTO_TCP, local_addr, 1, 19);
    for (i = 0; i < 20; i++) push_byte(8'h00, i == 19);
    wait_drained();
    rand_phase(80);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 36;
    cfg_write(REG_LOCAL_ADDRESS, 32'h0);
    cfg_write(REG_MAX_PACKET_LENGTH, 32'd20);
    @(negedge clk);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, PROTO_TCP, 32'h0, 1, 20);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, PROTO_TCP, 32'h0, 1, 21);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd64, 8'd2, 32'h0, 1, 20);
    build_packet(IPV4_VER, 4'd5, 16'd20, 8'd1, PROTO_ICMP, 32'h0, 1, 20);
    wait_drained();
    cfg_write(REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
    cfg_write(REG_MAX_PACKET_LENGTH, $urandom_range(20, 100));
    @(negedge clk);
    rand_phase(80);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_LOCAL_ADDRESS, $urandom);
    cfg_write(REG_MAX_PACKET_LENGTH, 32'h0000_FFFF);
    @(negedge clk);
    rand_phase(80);
    wait_drained();
    // receiver stalls while packets keep coming, so the input side backs up
    hold_req++;
    for (i = 0; i < 6; i++) rand_packet();
    while (hold_seen != hold_req || hold_cycles != 0) @(negedge clk);
    wait_drained();

    if (mismatch_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
